[rtl/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants of the sound generator
// State codes, register numbers, envelope shape bits and the volume table.
// ----------------------------------------------------------------------------
package psg_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_ENV,
    S_CHAN,
    S_DONE
  } state_t;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_VOL_B     = 4'd9;
  localparam logic [3:0] REG_VOL_C     = 4'd10;
  localparam logic [3:0] REG_ENV_FINE  = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [3:0] REG_TONE_LAST = 4'd5;

  localparam int SHAPE_CONT   = 3;
  localparam int SHAPE_ATTACK = 2;
  localparam int SHAPE_ALT    = 1;
  localparam int SHAPE_HOLD   = 0;

  localparam logic [16:0] LFSR_TAPS = 17'h12000;
  localparam logic [13:0] TONE_MAX  = 14'd16383;

  // Log volume curve scaled by 24 * 256, rounded, so full scale is 6144.
  function automatic logic [12:0] level_of(input logic [3:0] idx);
    logic [12:0] lv;
    unique case (idx)
      4'd0:  lv = 13'd0;
      4'd1:  lv = 13'd84;
      4'd2:  lv = 13'd126;
      4'd3:  lv = 13'd179;
      4'd4:  lv = 13'd260;
      4'd5:  lv = 13'd380;
      4'd6:  lv = 13'd521;
      4'd7:  lv = 13'd841;
      4'd8:  lv = 13'd1039;
      4'd9:  lv = 13'd1626;
      4'd10: lv = 13'd2167;
      4'd11: lv = 13'd2764;
      4'd12: lv = 13'd3504;
      4'd13: lv = 13'd4223;
      4'd14: lv = 13'd5211;
      default: lv = 13'd6144;
    endcase
    return lv;
  endfunction

endpackage

[rtl/three_channel_psg_tone_noise_envelope_unit.sv]
// ----------------------------------------------------------------------------
// three_channel_psg_tone_noise_envelope_unit: three-voice sound generator
// Register writes and ticks in, three channel levels out.
// ----------------------------------------------------------------------------
// Each input beat is either a register write or a tick. A write completes
// in its accepting cycle, except a tone period write that leaves the counter
// at or above twice the new period: that one then reduces the counter with a
// shift-subtract loop in S_MOD, from the top shift position down. A tick
// passes the accepting state S_IDLE, S_ENV to step the envelope, S_CHAN for
// each channel in turn through the shared tone adder/comparator (which also
// clocks the noise generator on the last channel), and S_DONE to hand the
// three levels to the output register; S_DONE stretches for as long as an
// earlier result still waits there unaccepted. The input is not ready while
// an item is in progress, but a finished result may wait in the output
// register while the next beat is taken. Writes produce no output beat; each tick produces exactly one.
module three_channel_psg_tone_noise_envelope_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [3:0]  reg_index,
  input  logic [7:0]  reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] level_a,
  output logic [12:0] level_b,
  output logic [12:0] level_c
);

  psg_pkg::state_t state, state_next;

  // Only the register bits that affect the sound are kept, but for the mixer, which keeps all eight.
  logic [7:0]  tone_fine [3];
  logic [3:0]  tone_coarse [3];
  logic [7:0]  mixer;
  logic [4:0]  vol [3];
  logic [3:0]  env_shape;

  logic [11:0] tone_div [3];
  logic [13:0] tone_acc [3];
  logic        tone_phase [3];
  logic [4:0]  noise_acc;
  logic [4:0]  noise_div;
  logic [16:0] lfsr;
  logic        noise_gate;
  logic [15:0] env_div;
  logic [15:0] env_count;
  logic [3:0]  env_step;
  logic [3:0]  env_substep;
  logic        env_first_pass;
  logic        env_reversed;

  logic [12:0] env_level;
  logic [12:0] lvl [3];
  logic [1:0]  ch;

  // Modulo loop state: remainder, doubled period and shift position.
  logic [13:0] mod_rem;
  logic [12:0] mod_div;
  logic [3:0]  mod_sh;

  wire accept_in = in_valid && in_ready;
  assign in_ready = (state == psg_pkg::S_IDLE);

  // Tone period that a write to registers 0..5 produces.
  logic [1:0]  wr_ch;
  logic [11:0] wr_period;
  logic [12:0] wr_double;
  always_comb begin
    wr_ch = reg_index[2:1];
    if (reg_index[0]) begin
      wr_period = {reg_value[3:0], tone_fine[wr_ch]};
    end else begin
      wr_period = {tone_coarse[wr_ch], reg_value};
    end
    if (wr_period == 12'd0) begin
      wr_period = 12'd1;
    end
    wr_double = {wr_period, 1'b0};
  end

  wire [26:0] mod_shifted = 27'(mod_div) << mod_sh;
  wire        mod_take    = {13'd0, mod_rem} >= mod_shifted;
  wire [13:0] mod_rem_new = mod_take ? (mod_rem - mod_shifted[13:0]) : mod_rem;

  // Envelope step for one tick.
  logic [16:0] env_inc;
  logic [15:0] env_count_next;
  logic [3:0]  env_step_next;
  logic [3:0]  env_substep_next;
  logic        env_first_pass_next;
  logic        env_reversed_next;
  logic        env_up;
  logic [4:0]  sub_inc;
  always_comb begin
    env_inc             = {1'b0, env_count} + 17'd1;
    env_count_next      = env_inc[15:0];
    env_step_next       = env_step;
    env_substep_next    = env_substep;
    env_first_pass_next = env_first_pass;
    env_reversed_next   = env_reversed;
    env_up              = env_shape[psg_pkg::SHAPE_ATTACK] ^ env_reversed;
    sub_inc             = {1'b0, env_substep} + 5'd1;
    if (env_inc >= {1'b0, env_div}) begin
      env_count_next = 16'd0;
      if (env_first_pass || (env_shape[psg_pkg::SHAPE_CONT] &&
                             !env_shape[psg_pkg::SHAPE_HOLD])) begin
        if (env_up) begin
          if (env_step != 4'd15) env_step_next = env_step + 4'd1;
        end else begin
          if (env_step != 4'd0) env_step_next = env_step - 4'd1;
        end
      end
      env_substep_next = sub_inc[3:0];
      if (sub_inc[4]) begin
        // End of one sixteen-step ramp: the shape decides what follows.
        env_substep_next = 4'd0;
        priority if (!env_shape[psg_pkg::SHAPE_CONT]) begin
          env_step_next = 4'd0;
        end else if (env_shape[psg_pkg::SHAPE_HOLD]) begin
          if (env_first_pass && env_shape[psg_pkg::SHAPE_ALT]) begin
            env_step_next = (env_step_next != 4'd0) ? 4'd0 : 4'd15;
          end
        end else if (env_shape[psg_pkg::SHAPE_ALT]) begin
          env_reversed_next = ~env_reversed;
        end else begin
          env_step_next = env_shape[psg_pkg::SHAPE_ATTACK] ? 4'd0 : 4'd15;
        end
        env_first_pass_next = 1'b0;
      end
    end
  end

  // Shared tone unit: one channel per cycle.
  logic [14:0] tone_sum;
  logic [13:0] tone_sat;
  logic        tone_wrap;
  logic [13:0] tone_acc_new;
  logic        tone_phase_new;
  logic [12:0] chan_level;
  always_comb begin
    tone_sum       = {1'b0, tone_acc[ch]} + 15'd2;
    tone_sat       = (tone_sum > {1'b0, psg_pkg::TONE_MAX}) ? psg_pkg::TONE_MAX
                                                            : tone_sum[13:0];
    tone_wrap      = tone_sat >= {2'b00, tone_div[ch]};
    tone_acc_new   = tone_wrap ? (tone_sat - {2'b00, tone_div[ch]}) : tone_sat;
    tone_phase_new = tone_phase[ch] ^ tone_wrap;
    chan_level     = vol[ch][4] ? env_level : psg_pkg::level_of(vol[ch][3:0]);
    if (!mixer[{1'b0, ch}] && !tone_phase_new) begin
      chan_level = 13'd0;
    end
    if (!mixer[3'({1'b0, ch}) + 3'd3] && noise_gate) begin
      chan_level = 13'd0;
    end
  end

  wire [5:0] noise_inc = {1'b0, noise_acc} + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psg_pkg::S_IDLE: begin
        if (accept_in) begin
          if (op == psg_pkg::OP_TICK) begin
            state_next = psg_pkg::S_ENV;
          end else if (reg_index <= psg_pkg::REG_TONE_LAST &&
                       tone_acc[wr_ch] >= {1'b0, wr_double}) begin
            state_next = psg_pkg::S_MOD;
          end
        end
      end
      psg_pkg::S_MOD:  if (mod_sh == 4'd0) state_next = psg_pkg::S_IDLE;
      psg_pkg::S_ENV:  state_next = psg_pkg::S_CHAN;
      psg_pkg::S_CHAN: if (ch == 2'd2) state_next = psg_pkg::S_DONE;
      psg_pkg::S_DONE: if (!out_valid || out_ready) state_next = psg_pkg::S_IDLE;
      default:         state_next = psg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        tone_fine[i]   <= 8'd0;
        tone_coarse[i] <= 4'd0;
        vol[i]         <= 5'd0;
        tone_div[i]    <= 12'd1;
        tone_acc[i]    <= 14'd0;
        tone_phase[i]  <= 1'b0;
      end
      mixer          <= 8'd0;
      env_shape      <= 4'd0;
      noise_acc      <= 5'd0;
      noise_div      <= 5'd0;
      lfsr           <= 17'd1;
      noise_gate     <= 1'b0;
      env_div        <= 16'd0;
      env_count      <= 16'd0;
      env_step       <= 4'd15;
      env_substep    <= 4'd0;
      env_first_pass <= 1'b1;
      env_reversed   <= 1'b0;
      ch             <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      // The output register loads when it is empty or being emptied.
      if (state == psg_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        psg_pkg::S_IDLE: begin
          ch <= (accept_in && op == psg_pkg::OP_WRITE &&
                 reg_index <= psg_pkg::REG_TONE_LAST) ? wr_ch : 2'd0;
          if (accept_in && op == psg_pkg::OP_WRITE) begin
            if (reg_index <= psg_pkg::REG_TONE_LAST) begin
              if (reg_index[0]) tone_coarse[wr_ch] <= reg_value[3:0];
              else              tone_fine[wr_ch]   <= reg_value;
              tone_div[wr_ch] <= wr_period;
              mod_rem <= tone_acc[wr_ch];
              mod_div <= wr_double;
              mod_sh  <= 4'd13;
            end else begin
              unique case (reg_index)
                psg_pkg::REG_NOISE: begin
                  noise_acc <= 5'd0;
                  noise_div <= reg_value[4:0];
                end
                psg_pkg::REG_MIXER: mixer <= reg_value;
                psg_pkg::REG_VOL_A: vol[0] <= reg_value[4:0];
                psg_pkg::REG_VOL_B: vol[1] <= reg_value[4:0];
                psg_pkg::REG_VOL_C: vol[2] <= reg_value[4:0];
                psg_pkg::REG_ENV_FINE:   env_div[7:0]  <= reg_value;
                psg_pkg::REG_ENV_COARSE: env_div[15:8] <= reg_value;
                psg_pkg::REG_ENV_SHAPE: begin
                  env_shape      <= reg_value[3:0];
                  env_count      <= 16'd0;
                  env_substep    <= 4'd0;
                  env_first_pass <= 1'b1;
                  env_reversed   <= 1'b0;
                  env_step       <= reg_value[psg_pkg::SHAPE_ATTACK] ? 4'd0 : 4'd15;
                end
                default: ;
              endcase
            end
          end
        end
        psg_pkg::S_MOD: begin
          // One quotient bit per cycle, from the top shift down.
          mod_rem <= mod_rem_new;
          mod_sh  <= mod_sh - 4'd1;
          if (mod_sh == 4'd0) begin
            tone_acc[ch] <= mod_rem_new;
          end
        end
        psg_pkg::S_ENV: begin
          // The level is taken from the step before the envelope moves.
          env_level      <= psg_pkg::level_of(env_step);
          env_count      <= env_count_next;
          env_step       <= env_step_next;
          env_substep    <= env_substep_next;
          env_first_pass <= env_first_pass_next;
          env_reversed   <= env_reversed_next;
        end
        psg_pkg::S_CHAN: begin
          if (!mixer[{1'b0, ch}]) begin
            tone_acc[ch]   <= tone_acc_new;
            tone_phase[ch] <= tone_phase_new;
          end
          lvl[ch] <= chan_level;
          ch      <= ch + 2'd1;
          if (ch == 2'd2) begin
            // Noise is clocked after all three channels used the old gate.
            if (noise_inc >= {1'b0, noise_div}) begin
              noise_acc  <= 5'd0;
              noise_gate <= noise_gate ^ lfsr[0] ^ lfsr[1];
              lfsr       <= (lfsr >> 1) ^ (lfsr[0] ? psg_pkg::LFSR_TAPS : 17'd0);
            end else begin
              noise_acc <= noise_inc[4:0];
            end
          end
        end
        psg_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            level_a <= lvl[0];
            level_b <= lvl[1];
            level_c <= lvl[2];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
